// ===== design/rmj_pkg.sv =====
// ----------------------------------------------------------------------------
// rmj_pkg: shared types and constants for the radar measurement Jacobian
// Holds the side-band records that travel down the square-root chain and
// the divider chain, and the quotient width of the divider cells.
// ----------------------------------------------------------------------------
package rmj_pkg;

    // quotient bits produced by the divider chain (every quotient < 2^57)
    localparam int QB = 57;

    // one square-root cell per result bit of the 32-bit root
    localparam int SQ_STEPS = 32;

    // record handed from the front end through the square-root chain
    typedef struct packed {
        logic        vld;
        logic        nx;
        logic        ny;
        logic        neg_d;
        logic        near;
        logic [31:0] mx;
        logic [31:0] my;
        logic [63:0] dmag;
        logic [63:0] r2;
    } t_front;

    // signs and flags that ride alongside the divider chain
    typedef struct packed {
        logic vld;
        logic nx;
        logic ny;
        logic neg_d;
        logic near;
    } t_tail;

endpackage

// ===== design/rmj_front.sv =====
// ----------------------------------------------------------------------------
// rmj_front: magnitudes, products, squared range and velocity cross term
// Four register stages: sign/magnitude split, 32x32 products, r2 and the
// signed cross-term difference, then the near-origin test and |difference|.
// ----------------------------------------------------------------------------
module rmj_front
    import rmj_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_position_x,
    input  logic signed [31:0] i_position_y,
    input  logic signed [31:0] i_velocity_x,
    input  logic signed [31:0] i_velocity_y,
    input  logic        [30:0] i_thr,
    output t_front             o_side
);

    // stage A: sign and magnitude
    logic        r_a_vld, r_a_nx, r_a_ny, r_a_nvx, r_a_nvy;
    logic [31:0] r_a_mx, r_a_my, r_a_mvx, r_a_mvy;
    logic [31:0] n_a_mx, n_a_my, n_a_mvx, n_a_mvy;

    always_comb begin
        n_a_mx  = i_position_x[31] ? 32'(-i_position_x) : i_position_x;
        n_a_my  = i_position_y[31] ? 32'(-i_position_y) : i_position_y;
        n_a_mvx = i_velocity_x[31] ? 32'(-i_velocity_x) : i_velocity_x;
        n_a_mvy = i_velocity_y[31] ? 32'(-i_velocity_y) : i_velocity_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_a_nx  <= i_position_x[31];
            r_a_ny  <= i_position_y[31];
            r_a_nvx <= i_velocity_x[31];
            r_a_nvy <= i_velocity_y[31];
            r_a_mx  <= n_a_mx;
            r_a_my  <= n_a_my;
            r_a_mvx <= n_a_mvx;
            r_a_mvy <= n_a_mvy;
        end
    end

    // stage B: squares and cross products
    logic        r_b_vld, r_b_nx, r_b_ny, r_b_sa, r_b_sb;
    logic [31:0] r_b_mx, r_b_my;
    logic [63:0] r_b_sqx, r_b_sqy, r_b_pa, r_b_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
            r_b_nx  <= r_a_nx;
            r_b_ny  <= r_a_ny;
            r_b_sa  <= r_a_nvx ^ r_a_ny;
            r_b_sb  <= r_a_nvy ^ r_a_nx;
            r_b_mx  <= r_a_mx;
            r_b_my  <= r_a_my;
            r_b_sqx <= 64'(r_a_mx) * 64'(r_a_mx);
            r_b_sqy <= 64'(r_a_my) * 64'(r_a_my);
            r_b_pa  <= 64'(r_a_mvx) * 64'(r_a_my);
            r_b_pb  <= 64'(r_a_mvy) * 64'(r_a_mx);
        end
    end

    // stage C: r2 and signed difference vx*py - vy*px
    logic        r_c_vld, r_c_nx, r_c_ny;
    logic [31:0] r_c_mx, r_c_my;
    logic [63:0] r_c_r2;
    logic [65:0] r_c_diff;
    logic [65:0] n_c_a, n_c_b;

    always_comb begin
        n_c_a = r_b_sa ? 66'(-{2'b00, r_b_pa}) : {2'b00, r_b_pa};
        n_c_b = r_b_sb ? 66'(-{2'b00, r_b_pb}) : {2'b00, r_b_pb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld  <= r_b_vld;
            r_c_nx   <= r_b_nx;
            r_c_ny   <= r_b_ny;
            r_c_mx   <= r_b_mx;
            r_c_my   <= r_b_my;
            r_c_r2   <= r_b_sqx + r_b_sqy;
            r_c_diff <= n_c_a - n_c_b;
        end
    end

    // stage D: near-origin test and magnitude of the difference
    t_front r_d;
    t_front n_d;

    always_comb begin
        n_d.vld   = r_c_vld;
        n_d.nx    = r_c_nx;
        n_d.ny    = r_c_ny;
        n_d.mx    = r_c_mx;
        n_d.my    = r_c_my;
        n_d.r2    = r_c_r2;
        n_d.neg_d = r_c_diff[65];
        n_d.dmag  = r_c_diff[65] ? 64'(-r_c_diff) : r_c_diff[63:0];
        n_d.near  = (r_c_r2 == 64'd0) || (r_c_r2 < {17'd0, i_thr, 16'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_side = r_d;

endmodule

// ===== design/rmj_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmj_sqrt_cell: one digit of the integer square root of r2
// Brings in the next two radicand bits, tries root*4+1 against the partial
// remainder and appends one root bit. Carries the item record along.
// ----------------------------------------------------------------------------
module rmj_sqrt_cell
    import rmj_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_front      i_side,
    input  logic [33:0] i_rem,
    input  logic [31:0] i_root,
    output t_front      o_side,
    output logic [33:0] o_rem,
    output logic [31:0] o_root
);

    t_front      r_side;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] n_t, n_trial;
    logic        n_ge;
    logic [33:0] n_rem;
    logic [31:0] n_root;

    // trial subtract of (root << 2) | 1
    always_comb begin
        n_t     = {i_rem, i_side.r2[63-2*STEP -: 2]};
        n_trial = {2'b00, i_root, 2'b01};
        n_ge    = (n_t >= n_trial);
        n_rem   = n_ge ? 34'(n_t - n_trial) : n_t[33:0];
        n_root  = {i_root[30:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== design/rmj_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmj_div_cell: one restoring-division step for two dividends, one divisor
// Shifts the next dividend bit into each remainder, subtracts the divisor
// where it fits and appends the quotient bit.
// ----------------------------------------------------------------------------
module rmj_div_cell
    import rmj_pkg::*;
#(
    parameter int DW   = 32,
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_d,
    input  logic [DW-1:0] i_rem_a,
    input  logic [DW-1:0] i_rem_b,
    input  logic [QB-1:0] i_num_a,
    input  logic [QB-1:0] i_num_b,
    input  logic [QB-1:0] i_q_a,
    input  logic [QB-1:0] i_q_b,
    output logic [DW-1:0] o_d,
    output logic [DW-1:0] o_rem_a,
    output logic [DW-1:0] o_rem_b,
    output logic [QB-1:0] o_num_a,
    output logic [QB-1:0] o_num_b,
    output logic [QB-1:0] o_q_a,
    output logic [QB-1:0] o_q_b
);

    logic [DW-1:0] r_d, r_rem_a, r_rem_b;
    logic [QB-1:0] r_num_a, r_num_b, r_q_a, r_q_b;
    logic [DW:0]   n_ta, n_tb, n_dx;
    logic          n_ge_a, n_ge_b;
    logic [DW-1:0] n_rem_a, n_rem_b;

    // compare and subtract on both lanes
    always_comb begin
        n_dx    = {1'b0, i_d};
        n_ta    = {i_rem_a, i_num_a[QB-1-STEP]};
        n_tb    = {i_rem_b, i_num_b[QB-1-STEP]};
        n_ge_a  = (n_ta >= n_dx);
        n_ge_b  = (n_tb >= n_dx);
        n_rem_a = n_ge_a ? DW'(n_ta - n_dx) : n_ta[DW-1:0];
        n_rem_b = n_ge_b ? DW'(n_tb - n_dx) : n_tb[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d     <= i_d;
            r_rem_a <= n_rem_a;
            r_rem_b <= n_rem_b;
            r_num_a <= i_num_a;
            r_num_b <= i_num_b;
            r_q_a   <= {i_q_a[QB-2:0], n_ge_a};
            r_q_b   <= {i_q_b[QB-2:0], n_ge_b};
        end
    end

    assign o_d     = r_d;
    assign o_rem_a = r_rem_a;
    assign o_rem_b = r_rem_b;
    assign o_num_a = r_num_a;
    assign o_num_b = r_num_b;
    assign o_q_a   = r_q_a;
    assign o_q_b   = r_q_b;

endmodule

// ===== design/rmj_div_chain.sv =====
// ----------------------------------------------------------------------------
// rmj_div_chain: row of QB division cells for a pair of quotients
// The remainder enters already holding the dividend bits above QB; the
// cells then produce the quotient MSB first, one bit per cell.
// ----------------------------------------------------------------------------
module rmj_div_chain
    import rmj_pkg::*;
#(
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_d,
    input  logic [DW-1:0] i_rem_a,
    input  logic [DW-1:0] i_rem_b,
    input  logic [QB-1:0] i_num_a,
    input  logic [QB-1:0] i_num_b,
    output logic [QB-1:0] o_q_a,
    output logic [QB-1:0] o_q_b
);

    logic [DW-1:0] w_d     [QB+1];
    logic [DW-1:0] w_rem_a [QB+1];
    logic [DW-1:0] w_rem_b [QB+1];
    logic [QB-1:0] w_num_a [QB+1];
    logic [QB-1:0] w_num_b [QB+1];
    logic [QB-1:0] w_q_a   [QB+1];
    logic [QB-1:0] w_q_b   [QB+1];

    assign w_d[0]     = i_d;
    assign w_rem_a[0] = i_rem_a;
    assign w_rem_b[0] = i_rem_b;
    assign w_num_a[0] = i_num_a;
    assign w_num_b[0] = i_num_b;
    assign w_q_a[0]   = '0;
    assign w_q_b[0]   = '0;

    // one cell per quotient bit
    for (genvar g = 0; g < QB; g++) begin : g_cell
        rmj_div_cell #(
            .DW   (DW),
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_d     (w_d[g]),
            .i_rem_a (w_rem_a[g]),
            .i_rem_b (w_rem_b[g]),
            .i_num_a (w_num_a[g]),
            .i_num_b (w_num_b[g]),
            .i_q_a   (w_q_a[g]),
            .i_q_b   (w_q_b[g]),
            .o_d     (w_d[g+1]),
            .o_rem_a (w_rem_a[g+1]),
            .o_rem_b (w_rem_b[g+1]),
            .o_num_a (w_num_a[g+1]),
            .o_num_b (w_num_b[g+1]),
            .o_q_a   (w_q_a[g+1]),
            .o_q_b   (w_q_b[g+1])
        );
    end

    assign o_q_a = w_q_a[QB];
    assign o_q_b = w_q_b[QB];

endmodule

// ===== design/radar_measurement_jacobian_top.sv =====
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_top: radar polar measurement Jacobian
// Computes px/r, py/r, -py/r2, px/r2 and the two range-rate terms of a
// constant-velocity state, Q16.16 in, saturating Q24.24 out.
//
//   channel   direction  handshake                payload
//   input     in         i_valid / o_stall        position_x/y, velocity_x/y
//   result    out        o_valid / i_stall        six entries, near_origin,
//                                                 saturated
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_data (min range sq.)
//
// One request per cycle unless o_stall is high; stages: 4 front-end stages, 32
// square root cells, 2 product stages, 57 divider cells and the output register.
// Reset clears the valid bits and loads the threshold with 7.
// The whole pipeline holds while the output register is full and stalled.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_top
    import rmj_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_position_x,
    input  logic signed [31:0] i_position_y,
    input  logic signed [31:0] i_velocity_x,
    input  logic signed [31:0] i_velocity_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_range_by_px,
    output logic signed [47:0] o_range_by_py,
    output logic signed [47:0] o_bearing_by_px,
    output logic signed [47:0] o_bearing_by_py,
    output logic signed [47:0] o_rate_by_px,
    output logic signed [47:0] o_rate_by_py,
    output logic               o_near_origin,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [30:0] i_cfg_data
);

    localparam logic [QB-1:0] C_POS_LIM = QB'(48'h7FFF_FFFF_FFFF);
    localparam logic [QB-1:0] C_NEG_LIM = QB'(48'h8000_0000_0000);

    // clip a quotient magnitude with its sign: {saturated, value}
    function automatic logic [48:0] f_clip(input logic [QB-1:0] q, input logic neg);
        logic [48:0] v;
        if (neg) begin
            if (q > C_NEG_LIM) v = {1'b1, 48'h8000_0000_0000};
            else               v = {1'b0, 48'(-q)};
        end else begin
            if (q > C_POS_LIM) v = {1'b1, 48'h7FFF_FFFF_FFFF};
            else               v = {1'b0, q[47:0]};
        end
        return v;
    endfunction

    logic w_en;
    logic r_ov;

    // pipeline advances unless the output register is held
    assign w_en        = !r_ov || !i_stall;
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    // threshold register
    logic [30:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 31'd7;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // front end and square root chain
    t_front      w_sq_side [SQ_STEPS+1];
    logic [33:0] w_sq_rem  [SQ_STEPS+1];
    logic [31:0] w_sq_root [SQ_STEPS+1];

    rmj_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_valid),
        .i_position_x (i_position_x),
        .i_position_y (i_position_y),
        .i_velocity_x (i_velocity_x),
        .i_velocity_y (i_velocity_y),
        .i_thr        (r_thr),
        .o_side       (w_sq_side[0])
    );

    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        rmj_sqrt_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_sq_side[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .o_side  (w_sq_side[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1])
        );
    end

    // stage E: 32x32 partial products of r2*r, mx*dmag, my*dmag
    t_front      w_s;
    t_tail       r_e_tail;
    logic [31:0] r_e_r, r_e_mx, r_e_my;
    logic [63:0] r_e_r2, r_e_r2lo, r_e_r2hi, r_e_xlo, r_e_xhi, r_e_ylo, r_e_yhi;

    assign w_s = w_sq_side[SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_tail.vld <= 1'b0;
        end else if (w_en) begin
            r_e_tail <= '{vld: w_s.vld, nx: w_s.nx, ny: w_s.ny,
                          neg_d: w_s.neg_d, near: w_s.near};
            r_e_r    <= w_sq_root[SQ_STEPS];
            r_e_r2   <= w_s.r2;
            r_e_mx   <= w_s.mx;
            r_e_my   <= w_s.my;
            r_e_r2lo <= 64'(w_s.r2[31:0]) * 64'(w_sq_root[SQ_STEPS]);
            r_e_r2hi <= 64'(w_s.r2[63:32]) * 64'(w_sq_root[SQ_STEPS]);
            r_e_xlo  <= 64'(w_s.mx) * 64'(w_s.dmag[31:0]);
            r_e_xhi  <= 64'(w_s.mx) * 64'(w_s.dmag[63:32]);
            r_e_ylo  <= 64'(w_s.my) * 64'(w_s.dmag[31:0]);
            r_e_yhi  <= 64'(w_s.my) * 64'(w_s.dmag[63:32]);
        end
    end

    // stage F: combine partial products into r3 and the cross numerators
    t_tail       r_f_tail;
    logic [31:0] r_f_r, r_f_mx, r_f_my;
    logic [63:0] r_f_r2;
    logic [95:0] r_f_r3, r_f_px, r_f_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_tail.vld <= 1'b0;
        end else if (w_en) begin
            r_f_tail <= r_e_tail;
            r_f_r    <= r_e_r;
            r_f_r2   <= r_e_r2;
            r_f_mx   <= r_e_mx;
            r_f_my   <= r_e_my;
            r_f_r3   <= {32'd0, r_e_r2lo} + {r_e_r2hi, 32'd0};
            r_f_px   <= {32'd0, r_e_xlo} + {r_e_xhi, 32'd0};
            r_f_py   <= {32'd0, r_e_ylo} + {r_e_yhi, 32'd0};
        end
    end

    // divider chains: by r, by r2, by r3
    logic [QB-1:0] w_q_rx, w_q_ry, w_q_by, w_q_bx, w_q_py, w_q_px;

    rmj_div_chain #(.DW(32)) u_div_r (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_d     (r_f_r),
        .i_rem_a ('0),
        .i_rem_b ('0),
        .i_num_a ({1'b0, r_f_mx, 24'd0}),
        .i_num_b ({1'b0, r_f_my, 24'd0}),
        .o_q_a   (w_q_rx),
        .o_q_b   (w_q_ry)
    );

    rmj_div_chain #(.DW(64)) u_div_r2 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_d     (r_f_r2),
        .i_rem_a ({49'd0, r_f_my[31:17]}),
        .i_rem_b ({49'd0, r_f_mx[31:17]}),
        .i_num_a ({r_f_my[16:0], 40'd0}),
        .i_num_b ({r_f_mx[16:0], 40'd0}),
        .o_q_a   (w_q_by),
        .o_q_b   (w_q_bx)
    );

    rmj_div_chain #(.DW(96)) u_div_r3 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_d     (r_f_r3),
        .i_rem_a ({33'd0, r_f_py[95:33]}),
        .i_rem_b ({33'd0, r_f_px[95:33]}),
        .i_num_a ({r_f_py[32:0], 24'd0}),
        .i_num_b ({r_f_px[32:0], 24'd0}),
        .o_q_a   (w_q_py),
        .o_q_b   (w_q_px)
    );

    // signs and flags aligned with the divider chains
    t_tail r_dt [QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) r_dt[k].vld <= 1'b0;
        end else if (w_en) begin
            r_dt[0] <= r_f_tail;
            for (int k = 1; k < QB; k++) r_dt[k] <= r_dt[k-1];
        end
    end

    // sign, clip and zero for near-origin
    t_tail       w_t;
    logic [48:0] n_c0, n_c1, n_c2, n_c3, n_c4, n_c5;
    logic        n_sat;

    assign w_t = r_dt[QB-1];

    always_comb begin
        n_c0  = f_clip(w_q_rx, w_t.nx);
        n_c1  = f_clip(w_q_ry, w_t.ny);
        n_c2  = f_clip(w_q_by, !w_t.ny);
        n_c3  = f_clip(w_q_bx, w_t.nx);
        n_c4  = f_clip(w_q_py, w_t.ny ^ w_t.neg_d);
        n_c5  = f_clip(w_q_px, w_t.nx == w_t.neg_d);
        n_sat = !w_t.near && (n_c0[48] || n_c1[48] || n_c2[48]
                              || n_c3[48] || n_c4[48] || n_c5[48]);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov            <= w_t.vld;
            o_range_by_px   <= w_t.near ? '0 : n_c0[47:0];
            o_range_by_py   <= w_t.near ? '0 : n_c1[47:0];
            o_bearing_by_px <= w_t.near ? '0 : n_c2[47:0];
            o_bearing_by_py <= w_t.near ? '0 : n_c3[47:0];
            o_rate_by_px    <= w_t.near ? '0 : n_c4[47:0];
            o_rate_by_py    <= w_t.near ? '0 : n_c5[47:0];
            o_near_origin   <= w_t.near;
            o_saturated     <= n_sat;
        end
    end

    assign o_valid = r_ov;

endmodule
